// ===== design/stack_machine_alu_top_defines.svh =====
// Assertion macros shared by the stack machine ALU checker.
`ifndef STACK_MACHINE_ALU_TOP_DEFINES_SVH
`define STACK_MACHINE_ALU_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SMA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sma_pkg.sv =====
// Shared constants, opcodes and request type of the stack machine ALU.
package sma_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int CMD_W      = 5;
  localparam int CMD_LSB    = 0;
  localparam int TOP_LSB    = CMD_LSB + CMD_W;
  localparam int NEXT_LSB   = TOP_LSB + DATA_WIDTH;
  localparam int S_TDATA_W  = ((NEXT_LSB + DATA_WIDTH + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    OP_ADD    = 5'd0,
    OP_SUB    = 5'd1,
    OP_MUL    = 5'd2,
    OP_NOT    = 5'd3,
    OP_OR     = 5'd4,
    OP_AND    = 5'd5,
    OP_XOR    = 5'd6,
    OP_EQ     = 5'd7,
    OP_NE     = 5'd8,
    OP_LT     = 5'd9,
    OP_GE     = 5'd10,
    OP_LE     = 5'd11,
    OP_GT     = 5'd12,
    OP_ZEQ    = 5'd13,
    OP_ZLT    = 5'd14,
    OP_ZGT    = 5'd15,
    OP_MIN    = 5'd16,
    OP_MAX    = 5'd17,
    OP_DBL    = 5'd18,
    OP_HALVE  = 5'd19,
    OP_ABS    = 5'd20,
    OP_NEGATE = 5'd21,
    OP_INC1   = 5'd22,
    OP_DEC1   = 5'd23,
    OP_INC2   = 5'd24,
    OP_DEC2   = 5'd25
  } op_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] next_value;
    logic [DATA_WIDTH-1:0] top_value;
    logic [CMD_W-1:0]      command;
  } sma_req_t;

endpackage

// ===== design/sma_alu.sv =====
// Combinational datapath of the stack machine ALU: all 26 operations and result select.
module sma_alu import sma_pkg::*; (
  input  logic                  signed_mode,
  input  sma_req_t              req,
  output logic [DATA_WIDTH-1:0] result
);

  localparam int W = DATA_WIDTH;
  localparam logic [W:0] ONE = (W+1)'(1);
  localparam logic [W:0] TWO = (W+1)'(2);

  logic [W-1:0]        a;
  logic [W-1:0]        b;
  logic [W:0]          ea;
  logic [W:0]          eb;
  logic [W:0]          sum;
  logic [W:0]          diff;
  logic [W:0]          neg;
  logic [W:0]          inc1;
  logic [W:0]          dec1;
  logic [W:0]          inc2;
  logic [W:0]          dec2;
  logic signed [2*W+1:0] prod;
  logic [W-1:0]        prod_word;
  logic [W-1:0]        dbl;
  logic [W-1:0]        halve;
  logic                lt;
  logic                gt;
  logic                a_neg;

  function automatic logic [W-1:0] pack_word(input logic sm, input logic [W:0] x);
    return sm ? {x[W], x[W-2:0]} : x[W-1:0];
  endfunction

  function automatic logic [W-1:0] flag(input logic c);
    return {W{c}};
  endfunction

  always_comb begin
    a     = req.top_value;
    b     = req.next_value;
    ea    = {signed_mode & a[W-1], a};
    eb    = {signed_mode & b[W-1], b};
    sum   = eb + ea;
    diff  = eb - ea;
    neg   = (W+1)'(0) - ea;
    inc1  = ea + ONE;
    dec1  = ea - ONE;
    inc2  = ea + TWO;
    dec2  = ea - TWO;
    prod  = $signed(ea) * $signed(eb);
    prod_word = signed_mode ? {prod[2*W+1], prod[W-2:0]} : prod[W-1:0];
    dbl   = signed_mode ? {a[W-1], a[W-3:0], 1'b0} : {a[W-2:0], 1'b0};
    halve = {signed_mode & a[W-1], a[W-1:1]};
    lt    = $signed(eb) < $signed(ea);
    gt    = $signed(eb) > $signed(ea);
    a_neg = signed_mode & a[W-1];
  end

  always_comb begin
    unique case (req.command)
      OP_ADD:    result = pack_word(signed_mode, sum);
      OP_SUB:    result = pack_word(signed_mode, diff);
      OP_MUL:    result = prod_word;
      OP_NOT:    result = ~a;
      OP_OR:     result = a | b;
      OP_AND:    result = a & b;
      OP_XOR:    result = a ^ b;
      OP_EQ:     result = flag(a == b);
      OP_NE:     result = flag(a != b);
      OP_LT:     result = flag(lt);
      OP_GE:     result = flag(!lt);
      OP_LE:     result = flag(!gt);
      OP_GT:     result = flag(gt);
      OP_ZEQ:    result = flag(a == '0);
      OP_ZLT:    result = flag(a_neg);
      OP_ZGT:    result = flag((a != '0) && !a_neg);
      OP_MIN:    result = gt ? a : b;
      OP_MAX:    result = lt ? a : b;
      OP_DBL:    result = dbl;
      OP_HALVE:  result = halve;
      OP_ABS:    result = a_neg ? pack_word(signed_mode, neg) : a;
      OP_NEGATE: result = signed_mode ? pack_word(signed_mode, neg) : a;
      OP_INC1:   result = pack_word(signed_mode, inc1);
      OP_DEC1:   result = pack_word(signed_mode, dec1);
      OP_INC2:   result = pack_word(signed_mode, inc2);
      OP_DEC2:   result = pack_word(signed_mode, dec2);
      default:   result = '0;
    endcase
  end

endmodule

// ===== design/stack_machine_alu_top.sv =====
// Top level of the stack machine ALU: request register, ALU and result register.
//
// A request on the s_axis channel carries an opcode, the top of stack and the
// next stack entry; each request gives exactly one result word on m_axis.
// cfg_wr_en/cfg_wr_data write the signed mode bit; write it only while no
// request is in flight.
// A request taken into the request register moves on to the result register
// once the result register is free or its result is being taken; the receiver
// then takes the result from the result register.
// Throughput: one request per cycle while the receiver is ready; the ALU
// is a single combinational pass between the two registers, the multiplier
// setting the critical path. When the receiver stalls the result holds in the
// result register and the request register still takes one more request;
// s_axis_tready drops only when both registers are full.
// Reset (rst, synchronous, active high) empties both registers and clears
// the signed mode to unsigned.
module stack_machine_alu_top import sma_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [4:0] command, [20:5] top_value, [36:21] next_value, [39:37] unused
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [15:0] result
  output logic [DATA_WIDTH-1:0] m_axis_tdata
);

  logic                  signed_mode;
  logic                  s1_valid;
  sma_req_t              s1_req;
  logic                  out_ready;
  logic [DATA_WIDTH-1:0] alu_result;

  assign out_ready     = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !s1_valid || out_ready;

  sma_alu u_alu (
    .signed_mode (signed_mode),
    .req         (s1_req),
    .result      (alu_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode   <= 1'b0;
      s1_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        signed_mode <= cfg_wr_data;
      end
      if (s_axis_tready) begin
        s1_valid <= s_axis_tvalid;
      end
      if (out_ready) begin
        m_axis_tvalid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_req.command    <= s_axis_tdata[CMD_LSB +: CMD_W];
      s1_req.top_value  <= s_axis_tdata[TOP_LSB +: DATA_WIDTH];
      s1_req.next_value <= s_axis_tdata[NEXT_LSB +: DATA_WIDTH];
    end
    if (out_ready && s1_valid) begin
      m_axis_tdata <= alu_result;
    end
  end

endmodule

// ===== design/sma_checker.sv =====
// Port-level assertions for the stack machine ALU, bound to the top level.
`include "stack_machine_alu_top_defines.svh"

module sma_checker import sma_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [S_TDATA_W-1:0]  s_axis_tdata,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [DATA_WIDTH-1:0] m_axis_tdata
);

  logic                  stalled;
  logic                  take;
  logic                  tnot;
  logic                  flow;
  logic [DATA_WIDTH-1:0] inv;

  assign stalled = m_axis_tvalid && !m_axis_tready;
  assign take    = s_axis_tvalid && s_axis_tready && m_axis_tready && !rst;
  assign tnot    = take && (s_axis_tdata[CMD_LSB +: CMD_W] == OP_NOT);
  assign flow    = m_axis_tready && !rst;
  assign inv     = ~s_axis_tdata[TOP_LSB +: DATA_WIDTH];

  `SMA_ASSERT_NEXT(a_out_hold, stalled, m_axis_tvalid && $stable(m_axis_tdata), "result not held")
  `SMA_ASSERT_IMPL(a_ready_free, m_axis_tready, s_axis_tready, "request refused")
  `SMA_ASSERT_IMPL(a_latency, $past(take, 2) && $past(flow), m_axis_tvalid, "result late")
  `SMA_ASSERT_IMPL(a_not, $past(tnot, 2) && $past(flow), m_axis_tdata == $past(inv, 2), "bad NOT")

endmodule

bind stack_machine_alu_top sma_checker u_sma_checker (.*);

// ===== sim/stack_machine_alu_top_test.sv =====
// Self-checking test of the stack machine ALU: directed and random requests in both modes.
module stack_machine_alu_top_test;
  import sma_pkg::*;

  localparam int FIRST_UNUSED = OP_DEC2 + 1;
  localparam int LAST_CMD = (1 << CMD_W) - 1;
  localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MIN_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] ALL_ONES = '1;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [DATA_WIDTH-1:0] m_axis_tdata;

  logic [DATA_WIDTH-1:0] expected_results[$];
  bit signed_mode_now;
  bit idling_on;
  int mismatch_count;
  int stall_left;

  stack_machine_alu_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [DATA_WIDTH-1:0] to_word(longint x, bit sgn);
    if (!sgn) return x[DATA_WIDTH-1:0];
    return {x[63], x[DATA_WIDTH-2:0]};
  endfunction

  function automatic logic [DATA_WIDTH-1:0] alu_result(logic [CMD_W-1:0] cmd,
                                                       logic [DATA_WIDTH-1:0] a,
                                                       logic [DATA_WIDTH-1:0] b,
                                                       bit sgn);
    longint sa;
    longint sb;
    sa = longint'(a);
    sb = longint'(b);
    if (sgn && a[DATA_WIDTH-1]) sa = sa - (longint'(1) << DATA_WIDTH);
    if (sgn && b[DATA_WIDTH-1]) sb = sb - (longint'(1) << DATA_WIDTH);
    case (cmd)
      OP_ADD:    return to_word(sb + sa, sgn);
      OP_SUB:    return to_word(sb - sa, sgn);
      OP_MUL:    return to_word(sa * sb, sgn);
      OP_NOT:    return ~a;
      OP_OR:     return a | b;
      OP_AND:    return a & b;
      OP_XOR:    return a ^ b;
      OP_EQ:     return {DATA_WIDTH{a == b}};
      OP_NE:     return {DATA_WIDTH{a != b}};
      OP_LT:     return {DATA_WIDTH{sb < sa}};
      OP_GE:     return {DATA_WIDTH{sb >= sa}};
      OP_LE:     return {DATA_WIDTH{sb <= sa}};
      OP_GT:     return {DATA_WIDTH{sb > sa}};
      OP_ZEQ:    return {DATA_WIDTH{a == '0}};
      OP_ZLT:    return {DATA_WIDTH{sgn && sa < 0}};
      OP_ZGT:    return {DATA_WIDTH{sa > 0}};
      OP_MIN:    return (sa < sb) ? a : b;
      OP_MAX:    return (sa > sb) ? a : b;
      OP_DBL:    return to_word(sa * 2, sgn);
      OP_HALVE:  return sgn ? {a[DATA_WIDTH-1], a[DATA_WIDTH-1:1]} : a >> 1;
      OP_ABS:    return sgn ? to_word(sa < 0 ? -sa : sa, sgn) : a;
      OP_NEGATE: return sgn ? to_word(-sa, sgn) : a;
      OP_INC1:   return to_word(sa + 1, sgn);
      OP_DEC1:   return to_word(sa - 1, sgn);
      OP_INC2:   return to_word(sa + 2, sgn);
      OP_DEC2:   return to_word(sa - 2, sgn);
      default:   return '0;
    endcase
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return MAX_POS;
      2: return MIN_NEG;
      3: return ALL_ONES;
      4: return DATA_WIDTH'($urandom_range(0, 2));
      default: return DATA_WIDTH'($urandom);
    endcase
  endfunction

  task automatic note_mismatch(string what, logic [DATA_WIDTH-1:0] want,
                               logic [DATA_WIDTH-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%s: expected %h got %h", what, want, got);
  endtask

  task automatic send_request(logic [CMD_W-1:0] cmd, logic [DATA_WIDTH-1:0] a,
                              logic [DATA_WIDTH-1:0] b);
    sma_req_t req;
    logic [S_TDATA_W-1:0] word;
    req.command = cmd;
    req.top_value = a;
    req.next_value = b;
    word = '0;
    word[$bits(sma_req_t)-1:0] = req;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= S_TDATA_W'({$urandom, $urandom});
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= word;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_results = {expected_results, alu_result(cmd, a, b, signed_mode_now)};
  endtask

  // hold off new requests until every result is back
  task automatic settle_pipeline();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_signed_mode(bit value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    signed_mode_now = value;
  endtask

  task automatic send_random_requests(int count);
    logic [CMD_W-1:0] cmd;
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) cmd = CMD_W'($urandom_range(FIRST_UNUSED, LAST_CMD));
      else cmd = CMD_W'($urandom_range(OP_ADD, OP_DEC2));
      a = pick_operand();
      b = ($urandom_range(0, 7) == 0) ? a : pick_operand();
      send_request(cmd, a, b);
    end
  endtask

  task automatic test_every_operation();
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
    write_signed_mode(1'b0);
    for (int i = OP_ADD; i <= FIRST_UNUSED; i++) begin
      case (i % 4)
        0: begin a = MIN_NEG; b = ALL_ONES; end
        1: begin a = MAX_POS; b = MAX_POS; end
        2: begin a = ALL_ONES; b = '0; end
        default: begin a = DATA_WIDTH'(1); b = MIN_NEG; end
      endcase
      send_request(CMD_W'(i), a, b);
    end
    send_request(CMD_W'(LAST_CMD), ALL_ONES, ALL_ONES);
    settle_pipeline();
  endtask

  task automatic test_signed_corners();
    write_signed_mode(1'b1);
    send_request(OP_ABS, MIN_NEG, '0);
    send_request(OP_NEGATE, MIN_NEG, '0);
    send_request(OP_INC1, MAX_POS, '0);
    send_request(OP_DEC2, MIN_NEG, '0);
    send_request(OP_ADD, MAX_POS, MAX_POS);
    send_request(OP_MUL, MIN_NEG, ALL_ONES);
    send_request(OP_HALVE, ALL_ONES, '0);
    send_request(OP_HALVE, MIN_NEG + 1'b1, '0);
    send_request(OP_ZLT, MIN_NEG, '0);
    send_request(OP_ZGT, ALL_ONES, '0);
    send_request(OP_LT, '0, ALL_ONES);
    send_request(OP_MIN, ALL_ONES, DATA_WIDTH'(1));
    send_request(OP_DBL, DATA_WIDTH'(3) << (DATA_WIDTH - 2), '0);
    settle_pipeline();
  endtask

  task automatic test_random_unsigned();
    write_signed_mode(1'b0);
    send_random_requests(120);
    settle_pipeline();
  endtask

  task automatic test_random_signed();
    write_signed_mode(1'b1);
    send_random_requests(120);
    settle_pipeline();
  endtask

  task automatic test_back_to_back();
    idling_on = 1'b0;
    write_signed_mode(1'b0);
    send_random_requests(60);
    settle_pipeline();
    write_signed_mode(1'b1);
    send_random_requests(60);
    settle_pipeline();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 15);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    logic [DATA_WIDTH-1:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected result", '0, m_axis_tdata);
      end else begin
        want = expected_results.pop_front();
        if (want !== m_axis_tdata) note_mismatch("result mismatch", want, m_axis_tdata);
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    signed_mode_now = 1'b0;
    idling_on = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_every_operation();
    test_signed_corners();
    test_random_unsigned();
    test_random_signed();
    test_back_to_back();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS stack_machine_alu_top");
    end else begin
      $display("FAIL stack_machine_alu_top");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL stack_machine_alu_top");
    $finish;
  end

endmodule
